### hw/rtl/cle_pkg.sv
// shared types and constants for the circular list engine
package cle_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_W        = 5;

    typedef enum logic [2:0] {
        OP_INS_END   = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_DEL_END   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_INS_KEY   = 3'd4,
        OP_DEL_KEY   = 3'd5,
        OP_READOUT   = 3'd6,
        OP_NONE      = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic signed [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] item;
        logic               last;
        logic [4:0]         count;
    } t_out_item;

endpackage

### hw/rtl/cle_ram.sv
// generic single-port-write ram with registered read
module cle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/circular_list_engine_unit.sv
// top level of the circular list engine: sequencer over value and link stores
// Inserts at either end take a slot off the free list directly; front deletes, end deletes,
// keyed ops and readout walk the list from the first entry one entry at a time, as set by
// the single read port of the link and value stores.
// After reset a clearing pass over every entry chains the free list; busy stays high
// meanwhile. Results appear one per strobe and cannot be held off; readout gives one
// result per entry.
module circular_list_engine_unit
    import cle_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  cle_pkg::t_in_item   i_in,
    output logic                o_valid,
    output cle_pkg::t_out_item  o_out
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_RD_WAIT, S_RD_USE, S_WALK_WAIT, S_WALK_USE,
        S_LINK1, S_LINK2, S_DONE
    } t_state;

    t_state          r_state;
    t_op             r_op;
    logic [31:0]     r_value, r_key, r_item;
    logic [AW-1:0]   r_first, r_final, r_free, r_cur, r_prev, r_new;
    logic [CW-1:0]   r_count, r_idx;
    logic [AW-1:0]   r_init;
    logic [1:0]      r_status;
    logic            r_head_hit;

    logic            lk_we, vl_we;
    logic [AW-1:0]   lk_waddr, lk_wdata, lk_raddr, vl_waddr, vl_raddr;
    logic [31:0]     vl_wdata, vl_rdata;
    logic [AW-1:0]   lk_rdata;
    logic            r_lk_we;
    logic [AW-1:0]   r_lk_waddr, r_lk_wdata, r_lk_raddr;
    logic            r_lk2_we;
    logic [AW-1:0]   r_lk2_waddr, r_lk2_wdata;

    cle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_waddr), .i_wdata(lk_wdata),
        .i_raddr(lk_raddr), .o_rdata(lk_rdata)
    );
    cle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_value (
        .i_clk(i_clk), .i_we(vl_we), .i_waddr(vl_waddr), .i_wdata(vl_wdata),
        .i_raddr(vl_raddr), .o_rdata(vl_rdata)
    );

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
        if (x == AW'(CAPACITY - 1)) begin
            return '0;
        end
        return x + AW'(1);
    endfunction

    // second link write port is sequenced: the stores have one write port, pending writes go
    // through r_lk2 on the next cycle
    assign lk_we    = r_lk_we;
    assign lk_waddr = r_lk_waddr;
    assign lk_wdata = r_lk_wdata;
    assign lk_raddr = r_lk_raddr;
    assign vl_raddr = r_cur;

    logic          r_vl_we;
    logic [AW-1:0] r_vl_waddr;
    assign vl_we    = r_vl_we;
    assign vl_waddr = r_vl_waddr;
    assign vl_wdata = r_value;

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init     <= '0;
            r_first    <= '0;
            r_final    <= '0;
            r_free     <= '0;
            r_count    <= '0;
            r_lk_we    <= 1'b0;
            r_lk2_we   <= 1'b0;
            r_vl_we    <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_lk_we  <= r_lk2_we;
            r_lk_waddr <= r_lk2_waddr;
            r_lk_wdata <= r_lk2_wdata;
            r_lk2_we <= 1'b0;
            r_vl_we  <= 1'b0;
            o_valid  <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_lk_we    <= 1'b1;
                    r_lk_waddr <= r_init;
                    r_lk_wdata <= wrap_inc(r_init);
                    r_init     <= wrap_inc(r_init);
                    if (r_init == AW'(CAPACITY - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_op    <= t_op'(i_in.op);
                        r_value <= i_in.value;
                        r_key   <= i_in.key;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_item     <= '0;
                    r_status   <= ST_OK;
                    r_cur      <= r_first;
                    r_prev     <= r_final;
                    r_idx      <= '0;
                    r_head_hit <= 1'b1;
                    unique case (r_op)
                        OP_INS_END, OP_INS_FRONT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                // read free list link of the slot taken
                                r_new      <= r_free;
                                r_lk_raddr <= r_free;
                                r_vl_we    <= 1'b1;
                                r_vl_waddr <= r_free;
                                r_state    <= S_RD_WAIT;
                            end
                        end
                        OP_DEL_END, OP_DEL_FRONT, OP_DEL_KEY, OP_READOUT, OP_INS_KEY: begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else if (r_op == OP_INS_KEY && r_count == CW'(CAPACITY)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_lk_raddr <= r_first;
                                r_state    <= S_WALK_WAIT;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_RD_WAIT: r_state <= S_RD_USE;
                S_RD_USE: begin
                    // insert of r_new in front of r_cur with predecessor r_prev
                    r_free <= lk_rdata;
                    r_lk_we <= 1'b1;
                    r_lk_waddr <= r_new;
                    r_lk2_we <= (r_count != '0);
                    r_lk2_waddr <= r_prev;
                    r_lk2_wdata <= r_new;
                    r_count <= r_count + CW'(1);
                    if (r_count == '0) begin
                        r_lk_wdata <= r_new;
                        r_first <= r_new;
                        r_final <= r_new;
                    end else begin
                        r_lk_wdata <= r_cur;
                        if (r_op == OP_INS_END) begin
                            r_final <= r_new;
                        end else if (r_head_hit) begin
                            r_first <= r_new;
                        end
                    end
                    if (r_op == OP_INS_END) begin
                        r_lk_wdata <= (r_count == '0) ? r_new : r_first;
                        r_lk2_waddr <= r_final;
                    end
                    r_state <= S_LINK1;
                end
                S_WALK_WAIT: r_state <= S_WALK_USE;
                S_WALK_USE: begin
                    // vl_rdata, lk_rdata are value and link of r_cur
                    logic hit;
                    hit = 1'b0;
                    unique case (r_op)
                        OP_READOUT: begin
                            o_valid <= 1'b1;
                            o_out.status <= ST_OK;
                            o_out.item <= vl_rdata;
                            o_out.last <= (r_idx + CW'(1) == r_count);
                            o_out.count <= COUNT_W'(r_count);
                            hit = (r_idx + CW'(1) == r_count);
                            if (hit) begin
                                r_state <= S_IDLE;
                            end
                        end
                        OP_DEL_FRONT: hit = 1'b1;
                        OP_DEL_END: hit = (r_idx + CW'(1) == r_count);
                        default: hit = (vl_rdata == r_key);
                    endcase
                    if (r_op != OP_READOUT) begin
                        if (hit) begin
                            if (r_op == OP_INS_KEY) begin
                                r_new      <= r_free;
                                r_lk_raddr <= r_free;
                                r_vl_we    <= 1'b1;
                                r_vl_waddr <= r_free;
                                r_state    <= S_RD_WAIT;
                            end else begin
                                // unlink r_cur: prev -> next, cur -> free
                                r_item <= vl_rdata;
                                r_lk_we <= 1'b1;
                                r_lk_waddr <= r_cur;
                                r_lk_wdata <= r_free;
                                r_free <= r_cur;
                                r_lk2_we <= (r_count != CW'(1));
                                r_lk2_waddr <= r_prev;
                                r_lk2_wdata <= lk_rdata;
                                r_count <= r_count - CW'(1);
                                if (r_count != CW'(1)) begin
                                    if (r_head_hit) begin
                                        r_first <= lk_rdata;
                                    end
                                    if (r_cur == r_final) begin
                                        r_final <= r_prev;
                                    end
                                end
                                r_state <= S_LINK1;
                            end
                        end else if (r_idx + CW'(1) == r_count) begin
                            r_status <= ST_NOT_FOUND;
                            r_state <= S_DONE;
                        end
                    end
                    if (!hit) begin
                        r_prev     <= r_cur;
                        r_cur      <= lk_rdata;
                        r_lk_raddr <= lk_rdata;
                        r_idx      <= r_idx + CW'(1);
                        r_head_hit <= 1'b0;
                        if (!(r_op != OP_READOUT && r_idx + CW'(1) == r_count)) begin
                            r_state <= S_WALK_WAIT;
                        end
                    end
                end
                S_LINK1: r_state <= S_LINK2;
                S_LINK2: r_state <= S_DONE;
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_out.status <= r_status;
                    o_out.item <= r_item;
                    o_out.last <= 1'b1;
                    o_out.count <= COUNT_W'(r_count);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count beyond capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && start) |=> busy) else $error("item not taken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status != ST_OK) |-> o_out.last) else $error("error not last");
endmodule

### tb/circular_list_engine_unit_test.sv
// testbench for the circular list engine: directed and random list operations
module circular_list_engine_unit_test;
    import cle_pkg::*;

    localparam int LIST_CAP = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_in;
    logic      o_valid;
    t_out_item o_out;

    circular_list_engine_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    // list state mirrored as an ordered queue of values
    logic signed [31:0] list_values[$];
    t_out_item          expected_results[$];
    int                 error_count;
    int                 idle_cycles;
    bit                 timed_out;
    logic signed [31:0] seen_values[$];

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic t_out_item make_result(input t_status st, input logic signed [31:0] v,
                                              input logic lst);
        t_out_item r;
        r.status = st;
        r.item   = v;
        r.last   = lst;
        r.count  = COUNT_W'(list_values.size());
        return r;
    endfunction

    function automatic int find_key(input logic signed [31:0] key);
        for (int i = 0; i < list_values.size(); i++) begin
            if (list_values[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic predict_list_op(input t_in_item it);
        int pos;
        logic signed [31:0] v;
        case (t_op'(it.op))
            OP_INS_END, OP_INS_FRONT: begin
                if (list_values.size() >= LIST_CAP) begin
                    expected_results.push_back(make_result(ST_FULL, 0, 1'b1));
                end else begin
                    if (it.op == OP_INS_END) list_values.push_back(it.value);
                    else list_values.push_front(it.value);
                    expected_results.push_back(make_result(ST_OK, 0, 1'b1));
                end
            end
            OP_DEL_END, OP_DEL_FRONT: begin
                if (list_values.size() == 0) begin
                    expected_results.push_back(make_result(ST_EMPTY, 0, 1'b1));
                end else begin
                    if (it.op == OP_DEL_END) v = list_values.pop_back();
                    else v = list_values.pop_front();
                    expected_results.push_back(make_result(ST_OK, v, 1'b1));
                end
            end
            OP_INS_KEY: begin
                pos = find_key(it.key);
                if (list_values.size() == 0) begin
                    expected_results.push_back(make_result(ST_EMPTY, 0, 1'b1));
                end else if (list_values.size() >= LIST_CAP) begin
                    expected_results.push_back(make_result(ST_FULL, 0, 1'b1));
                end else if (pos < 0) begin
                    expected_results.push_back(make_result(ST_NOT_FOUND, 0, 1'b1));
                end else begin
                    list_values.insert(pos, it.value);
                    expected_results.push_back(make_result(ST_OK, 0, 1'b1));
                end
            end
            OP_DEL_KEY: begin
                pos = find_key(it.key);
                if (list_values.size() == 0) begin
                    expected_results.push_back(make_result(ST_EMPTY, 0, 1'b1));
                end else if (pos < 0) begin
                    expected_results.push_back(make_result(ST_NOT_FOUND, 0, 1'b1));
                end else begin
                    v = list_values[pos];
                    list_values.delete(pos);
                    expected_results.push_back(make_result(ST_OK, v, 1'b1));
                end
            end
            OP_READOUT: begin
                if (list_values.size() == 0) begin
                    expected_results.push_back(make_result(ST_EMPTY, 0, 1'b1));
                end else begin
                    foreach (list_values[i]) begin
                        expected_results.push_back(make_result(ST_OK, list_values[i],
                            i == list_values.size() - 1));
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_item(input t_op op, input logic signed [31:0] v,
                             input logic signed [31:0] key);
        t_in_item it;
        it.op    = op;
        it.value = v;
        it.key   = key;
        i_in  = it;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        predict_list_op(it);
        if (op == OP_INS_END || op == OP_INS_FRONT || op == OP_INS_KEY) begin
            seen_values.push_back(v);
        end
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // sender gaps: random bursts with random idle stretches
    int burst_left;
    task automatic maybe_gap();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 40)) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_key();
        if (list_values.size() != 0 && $urandom_range(0, 3) != 0) begin
            return list_values[$urandom_range(0, list_values.size() - 1)];
        end
        if (seen_values.size() != 0 && $urandom_range(0, 1) != 0) begin
            return seen_values[$urandom_range(0, seen_values.size() - 1)];
        end
        return pick_value();
    endfunction

    task automatic test_empty_list();
        send_item(OP_DEL_END, 0, 0);
        send_item(OP_DEL_FRONT, 0, 0);
        send_item(OP_INS_KEY, 5, 5);
        send_item(OP_DEL_KEY, 0, 5);
        send_item(OP_READOUT, 0, 0);
        send_item(OP_NONE, 32'sh1234, 0);
    endtask

    task automatic test_basic_ops();
        send_item(OP_INS_END, 32'sh7fff_ffff, 0);
        send_item(OP_INS_FRONT, 32'sh8000_0000, 0);
        send_item(OP_INS_END, -1, 0);
        send_item(OP_INS_KEY, 42, 32'sh8000_0000);
        send_item(OP_INS_KEY, 43, -1);
        send_item(OP_INS_KEY, 44, 99);
        send_item(OP_READOUT, 0, 0);
        send_item(OP_DEL_KEY, 0, 42);
        send_item(OP_DEL_KEY, 0, -1);
        send_item(OP_DEL_KEY, 0, 99);
        send_item(OP_DEL_END, 0, 0);
        send_item(OP_DEL_FRONT, 0, 0);
        send_item(OP_READOUT, 0, 0);
    endtask

    task automatic test_full_list();
        repeat (LIST_CAP - list_values.size()) send_item(OP_INS_END, $urandom, 0);
        send_item(OP_INS_END, 1, 0);
        send_item(OP_INS_FRONT, 1, 0);
        send_item(OP_INS_KEY, 1, list_values[0]);
        send_item(OP_READOUT, 0, 0);
        repeat (LIST_CAP) send_item(OP_DEL_END, 0, 0);
    endtask

    task automatic test_random_ops(input int n);
        t_op op;
        int  fill_bias;
        for (int k = 0; k < n; k++) begin
            maybe_gap();
            fill_bias = (k / 60) % 2;
            case ($urandom_range(0, 15))
                0, 1, 2:  op = fill_bias ? OP_INS_END : OP_DEL_END;
                3, 4:     op = OP_INS_FRONT;
                5, 6:     op = fill_bias ? OP_INS_END : OP_DEL_FRONT;
                7, 8, 9:  op = OP_INS_KEY;
                10, 11:   op = OP_DEL_KEY;
                12, 13:   op = OP_READOUT;
                14:       op = OP_DEL_END;
                default:  op = ($urandom_range(0, 3) == 0) ? OP_NONE : OP_INS_END;
            endcase
            send_item(op, pick_value(), pick_key());
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item %p", o_out));
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out.status !== exp_r.status)
                    report_mismatch($sformatf("status %0d expected %0d", o_out.status,
                        exp_r.status));
                if (o_out.item !== exp_r.item)
                    report_mismatch($sformatf("item %0d expected %0d", o_out.item,
                        exp_r.item));
                if (o_out.last !== exp_r.last)
                    report_mismatch($sformatf("last %0d expected %0d", o_out.last,
                        exp_r.last));
                if (o_out.count !== exp_r.count)
                    report_mismatch($sformatf("count %0d expected %0d", o_out.count,
                        exp_r.count));
            end
        end
    end

    // watchdog on cycles with nothing accepted and no result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("circular_list_engine_unit_test: errors");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        burst_left  = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_random_ops(400);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2 * LIST_CAP + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("circular_list_engine_unit_test: clean");
        end else begin
            $display("circular_list_engine_unit_test: errors");
        end
        $finish;
    end

endmodule
